@@ src/mlp_pkg.sv @@
// Shared constants, codes and types for the dense forward-pass block.
// Used by mlp_mac and mlp_dense_forward_pass; no dependencies.
package mlp_pkg;

  // fixed widths of the Q8.8 datapath
  localparam int DATA_W = 16;
  localparam int FRAC_W = 8;
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = 40;

  // register file shape
  localparam int SIZE_REGS = 4;
  localparam int LCNT_W    = 3;
  localparam int SIZE_W    = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 6;

  // field widths of an input beat
  localparam int FUNC_W   = 2;
  localparam int TLAYER_W = 2;
  localparam int TIDX_W   = 5;

  localparam int MAX_LAYERS_DEF = 4;
  localparam int MAX_WIDTH_DEF  = 32;

  typedef enum logic [FUNC_W-1:0] {
    FN_WEIGHT = 2'd0,
    FN_BIAS   = 2'd1,
    FN_INPUT  = 2'd2,
    FN_NONE   = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAYER_COUNT = 3'd0,
    CFG_LAYER0_SIZE = 3'd1,
    CFG_LAYER1_SIZE = 3'd2,
    CFG_LAYER2_SIZE = 3'd3,
    CFG_LAYER3_SIZE = 3'd4
  } cfg_idx_e;

  // sequencer to MAC unit
  typedef struct packed {
    logic clear;
    logic mul_v;
    logic bias_add;
  } mac_ctrl_t;

endpackage

@@ src/mlp_mac.sv @@
// Shared multiply-accumulate unit: registered 16x16 product, 40-bit accumulator,
// bias add and Q8.8 truncate/saturate. Depends on mlp_pkg.
module mlp_mac (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mlp_pkg::mac_ctrl_t               ctrl_i,
  input  logic signed [mlp_pkg::DATA_W-1:0] weight_i,
  input  logic signed [mlp_pkg::DATA_W-1:0] value_i,
  input  logic signed [mlp_pkg::DATA_W-1:0] bias_i,
  output logic                             busy_o,
  output logic signed [mlp_pkg::DATA_W-1:0] q_o,
  output logic                             clip_o
);
  import mlp_pkg::*;

  localparam int HI_W = ACC_W - FRAC_W - DATA_W + 1;

  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_v_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic [HI_W-1:0]          hi;
  logic                     over, under;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (ctrl_i.bias_add) begin
      acc_d = acc_q + {{(ACC_W-DATA_W-FRAC_W){bias_i[DATA_W-1]}}, bias_i, {FRAC_W{1'b0}}};
    end else if (prod_v_q) begin
      acc_d = acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
      acc_q    <= '0;
    end else begin
      prod_v_q <= ctrl_i.mul_v;
      acc_q    <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_v) begin
      prod_q <= weight_i * value_i;
    end
  end

  // floor to Q8.8 is dropping the low fraction bits; clip when the upper bits
  // are not a pure sign extension
  assign hi    = acc_q[ACC_W-1:FRAC_W+DATA_W-1];
  assign over  = !acc_q[ACC_W-1] && (|hi);
  assign under = acc_q[ACC_W-1] && !(&hi);

  always_comb begin
    if (over) begin
      q_o = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (under) begin
      q_o = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      q_o = acc_q[FRAC_W+DATA_W-1:FRAC_W];
    end
  end

  assign clip_o = over || under;
  assign busy_o = prod_v_q;

endmodule

@@ src/mlp_dense_forward_pass.sv @@
// Top level of the dense forward-pass block: intake, weight and value memories,
// pass sequencer and output register. Depends on mlp_pkg and mlp_mac.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one beat per cycle while idle:
//   weight writes, layer bias writes and input vector elements. An element beat
//   with in_last_i set starts a pass; in_ready_o stays low until that pass has
//   placed its result in the output register.
//   Output channel (out_valid_o/out_ready_i) carries one beat per pass: neuron 0
//   of the final layer and the clip flag. The result sits in an output register,
//   so intake reopens while it waits; a further pass stalls at its end until the
//   receiver takes the pending beat.
//   Configuration channel (cfg_valid_i/cfg_ready_o) is always ready; write only
//   while no pass is running.
//   Pass flow: one shared multiplier/accumulator does all the work. For each
//   neuron of layer L it clears, accumulates over layer L-1, adds the bias and
//   stores; results are copied back per layer, with setup and readout added.
//   Reset: registers return to layer_count 2, all sizes 1, biases zero.
//   Weight and value memories are not cleared.
module mlp_dense_forward_pass #(
  parameter int MAX_LAYERS = mlp_pkg::MAX_LAYERS_DEF,
  parameter int MAX_WIDTH  = mlp_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mlp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mlp_pkg::CFG_DAT_W-1:0]      cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [mlp_pkg::FUNC_W-1:0]         in_func_i,
  input  logic [mlp_pkg::TLAYER_W-1:0]       in_target_layer_i,
  input  logic [mlp_pkg::TIDX_W-1:0]         in_target_neuron_i,
  input  logic [mlp_pkg::TIDX_W-1:0]         in_source_index_i,
  input  logic signed [mlp_pkg::DATA_W-1:0]  in_value_i,
  input  logic                               in_last_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [mlp_pkg::DATA_W-1:0]  out_prediction_o,
  output logic                               out_saturated_o
);
  import mlp_pkg::*;

  localparam int WLW   = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int WNW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int WA_W  = WLW + 2 * WNW;
  localparam int VA_W  = WNW + 1;
  localparam int LCAP  = (MAX_LAYERS < SIZE_REGS) ? MAX_LAYERS : SIZE_REGS;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LAYER, ST_NEURON, ST_MAC, ST_DRAIN,
    ST_BIAS, ST_STORE, ST_COPY, ST_READ0, ST_RESULT
  } state_e;

  // ---------------------------------------------------------------------------
  // configuration
  logic [LCNT_W-1:0]  lc_q;
  logic [SIZE_W-1:0]  size_q [SIZE_REGS];
  logic               cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_q <= LCNT_W'(2);
      for (int i = 0; i < SIZE_REGS; i++) size_q[i] <= SIZE_W'(1);
    end else if (cfg_we) begin
      if (cfg_index_i == CFG_LAYER_COUNT) begin
        lc_q <= cfg_data_i[LCNT_W-1:0];
      end else if (cfg_index_i <= CFG_LAYER3_SIZE) begin
        size_q[2'(cfg_index_i - CFG_LAYER0_SIZE)] <= cfg_data_i[SIZE_W-1:0];
      end
    end
  end

  function automatic logic [CW-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [CW-1:0] r;
    if (s == '0) begin
      r = CW'(1);
    end else if (32'(s) > MAX_WIDTH) begin
      r = CW'(MAX_WIDTH);
    end else begin
      r = CW'(s);
    end
    return r;
  endfunction

  logic [LCNT_W-1:0] eff_layers;

  always_comb begin
    if (lc_q == '0) begin
      eff_layers = LCNT_W'(1);
    end else if (32'(lc_q) > LCAP) begin
      eff_layers = LCNT_W'(LCAP);
    end else begin
      eff_layers = lc_q;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer state
  state_e             state_q;
  logic [LCNT_W-1:0]  layer_q;
  logic [LCNT_W-1:0]  layer_prev;
  logic [CW-1:0]      j_q, k_q, n_q, p_q;
  logic               rd_v_q, cp_v_q;
  logic [WNW-1:0]     cp_idx_q;
  logic               sat_q;
  logic               out_valid_q, osat_q;
  logic signed [DATA_W-1:0] pred_q;

  logic in_acc, in_start, out_free, mac_issue, cp_issue;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_start   = in_acc && (in_func_i == FN_INPUT) && in_last_i;
  assign out_free   = !out_valid_q || out_ready_i;
  assign mac_issue  = (state_q == ST_MAC);
  assign cp_issue   = (state_q == ST_COPY) && (k_q != n_q);
  assign layer_prev = layer_q - LCNT_W'(1);

  // ---------------------------------------------------------------------------
  // bias registers
  logic signed [DATA_W-1:0] bias_q [SIZE_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SIZE_REGS; i++) bias_q[i] <= '0;
    end else if (in_acc && in_func_i == FN_BIAS && 32'(in_target_layer_i) < MAX_LAYERS) begin
      bias_q[in_target_layer_i] <= in_value_i;
    end
  end

  // ---------------------------------------------------------------------------
  // weight memory: {layer, neuron, source}
  logic signed [DATA_W-1:0] wmem [2**WA_W];
  logic signed [DATA_W-1:0] wrd_q;
  logic                     w_we;
  logic [WA_W-1:0]          w_waddr, w_raddr;

  assign w_we = in_acc && (in_func_i == FN_WEIGHT)
             && (32'(in_target_layer_i) < MAX_LAYERS)
             && (32'(in_target_neuron_i) < MAX_WIDTH)
             && (32'(in_source_index_i) < MAX_WIDTH);
  assign w_waddr = {WLW'(in_target_layer_i), WNW'(in_target_neuron_i),
                    WNW'(in_source_index_i)};
  assign w_raddr = {WLW'(layer_q), j_q[WNW-1:0], k_q[WNW-1:0]};

  always_ff @(posedge clk_i) begin
    if (w_we) begin
      wmem[w_waddr] <= in_value_i;
    end
    wrd_q <= wmem[w_raddr];
  end

  // ---------------------------------------------------------------------------
  // value memory: bank 0 current layer, bank 1 layer under computation
  logic signed [DATA_W-1:0] vmem [2**VA_W];
  logic signed [DATA_W-1:0] vrd_q;
  logic signed [DATA_W-1:0] v_wdata;
  logic                     v_we;
  logic [VA_W-1:0]          v_waddr, v_raddr;
  logic signed [DATA_W-1:0] mac_q;
  logic                     mac_clip, mac_busy;

  always_comb begin
    v_we    = 1'b0;
    v_waddr = {1'b0, WNW'(in_source_index_i)};
    v_wdata = in_value_i;
    if (state_q == ST_IDLE) begin
      v_we = in_acc && (in_func_i == FN_INPUT) && (32'(in_source_index_i) < MAX_WIDTH);
    end else if (state_q == ST_STORE) begin
      v_we    = 1'b1;
      v_waddr = {1'b1, j_q[WNW-1:0]};
      v_wdata = mac_q;
    end else if (cp_v_q) begin
      v_we    = 1'b1;
      v_waddr = {1'b0, cp_idx_q};
      v_wdata = vrd_q;
    end
  end

  always_comb begin
    case (state_q)
      ST_MAC:  v_raddr = {1'b0, k_q[WNW-1:0]};
      ST_COPY: v_raddr = {1'b1, k_q[WNW-1:0]};
      default: v_raddr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (v_we) begin
      vmem[v_waddr] <= v_wdata;
    end
    vrd_q <= vmem[v_raddr];
  end

  // ---------------------------------------------------------------------------
  // shared MAC unit
  mac_ctrl_t mac_ctrl;

  assign mac_ctrl.clear    = (state_q == ST_NEURON);
  assign mac_ctrl.mul_v    = rd_v_q;
  assign mac_ctrl.bias_add = (state_q == ST_BIAS);

  mlp_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .weight_i (wrd_q),
    .value_i  (vrd_q),
    .bias_i   (bias_q[layer_q[1:0]]),
    .busy_o   (mac_busy),
    .q_o      (mac_q),
    .clip_o   (mac_clip)
  );

  // ---------------------------------------------------------------------------
  // pass sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      layer_q     <= '0;
      j_q         <= '0;
      k_q         <= '0;
      n_q         <= '0;
      p_q         <= '0;
      rd_v_q      <= 1'b0;
      cp_v_q      <= 1'b0;
      cp_idx_q    <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      osat_q      <= 1'b0;
      pred_q      <= '0;
    end else begin
      rd_v_q <= mac_issue;
      cp_v_q <= cp_issue;
      if (cp_issue) begin
        cp_idx_q <= k_q[WNW-1:0];
      end
      // in ST_RESULT the valid flag is handled by the state below
      if (out_valid_q && out_ready_i && state_q != ST_RESULT) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_start) begin
            sat_q   <= 1'b0;
            layer_q <= LCNT_W'(1);
            state_q <= ST_LAYER;
          end
        end
        ST_LAYER: begin
          if (layer_q >= eff_layers) begin
            state_q <= ST_READ0;
          end else begin
            n_q     <= eff_size(size_q[layer_q[1:0]]);
            p_q     <= eff_size(size_q[layer_prev[1:0]]);
            j_q     <= '0;
            state_q <= ST_NEURON;
          end
        end
        ST_NEURON: begin
          k_q     <= '0;
          state_q <= ST_MAC;
        end
        ST_MAC: begin
          k_q <= k_q + CW'(1);
          if (k_q == p_q - CW'(1)) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!rd_v_q && !mac_busy) begin
            state_q <= ST_BIAS;
          end
        end
        ST_BIAS: begin
          state_q <= ST_STORE;
        end
        ST_STORE: begin
          sat_q <= sat_q | mac_clip;
          if (j_q == n_q - CW'(1)) begin
            k_q     <= '0;
            state_q <= ST_COPY;
          end else begin
            j_q     <= j_q + CW'(1);
            state_q <= ST_NEURON;
          end
        end
        ST_COPY: begin
          if (cp_issue) begin
            k_q <= k_q + CW'(1);
          end else if (!cp_v_q) begin
            layer_q <= layer_q + LCNT_W'(1);
            state_q <= ST_LAYER;
          end
        end
        ST_READ0: begin
          state_q <= ST_RESULT;
        end
        ST_RESULT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            pred_q      <= vrd_q;
            osat_q      <= sat_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_prediction_o = pred_q;
  assign out_saturated_o  = osat_q;

endmodule
